### rtl/core/point_in_polygon_crossing_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
// Expects i_clk and active-low i_rst_n in the scope of each use.
`ifndef POINT_IN_POLYGON_CROSSING_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_MACROS_SVH

// Same-cycle implication.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pip_pkg.sv
// Shared types and constants for the point-in-polygon block.
// No dependencies.
package pip_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int CMD_W   = 2;
    localparam int TOTAL_W = 11;
    localparam int VTX_W   = LAT_W + LON_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic take;      // input transaction accepted this cycle
        logic rd_prime;  // read of the last vertex, seeds the previous-vertex reg
        logic rd_edge;   // read of vertex i, one edge per read
        logic finish;    // query done, load parity into the output reg
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // no vertices held
        logic out_hold;  // output reg full and stalled
        logic busy;      // edge pipeline still holds work
    } t_sts;

endpackage

### rtl/core/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/pip_datapath.sv
// Datapath: vertex count, vertex memory, edge-test pipeline, parity and output reg.
// Depends on pip_pkg, pip_ram and the assertion macro header.
`include "point_in_polygon_crossing_macros.svh"

module pip_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int CW           = $clog2(MAX_VERTICES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pip_pkg::t_ctl              i_ctl,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [pip_pkg::CMD_W-1:0]  i_cmd,
    input  logic [pip_pkg::LAT_W-1:0]  i_coord_lat,
    input  logic [pip_pkg::LON_W-1:0]  i_coord_lon,
    input  logic                       i_out_stall,
    output pip_pkg::t_sts              o_sts,
    output logic [AW-1:0]              o_last_addr,
    output logic                       o_out_valid,
    output logic                       o_inside_res,
    output logic                       o_status,
    output logic [pip_pkg::TOTAL_W-1:0] o_vertex_total
);

    import pip_pkg::*;

    // vertex count and table writes
    logic [CW-1:0]    r_count, n_count, w_last;
    logic             w_full, w_wr_en, w_load, w_res_inside, w_res_status;
    logic [VTX_W-1:0] w_rd_data;

    // query point
    logic signed [LAT_W-1:0] r_plat;
    logic signed [LON_W-1:0] r_plon;

    // read tags, aligned with RAM output
    logic r_rd_prime, r_rd_edge;

    logic signed [LAT_W-1:0] r_prev_lat, w_cur_lat;
    logic signed [LON_W-1:0] r_prev_lon, w_cur_lon;

    // stage 1: differences
    logic                    r_s1_vld, r_s1_str, r_s1_neg;
    logic signed [31:0]      r_span, r_dlat_p;
    logic signed [32:0]      r_dlon_p, r_dlon_e;

    // stage 2: partial products, longitude difference split at bit 16
    logic                    r_s2_vld, r_s2_str, r_s2_neg;
    logic signed [16:0]      w_pl_hi, w_pl_lo, w_el_hi, w_el_lo;
    logic signed [48:0]      r_lp_hi, r_lp_lo, r_rp_hi, r_rp_lo;

    // stage 3: full products
    logic                    r_s3_vld, r_s3_str, r_s3_neg;
    logic signed [65:0]      r_lhs, r_rhs;

    logic                    r_parity, w_cross;

    logic                    r_out_valid, r_inside, r_status;
    logic [TOTAL_W-1:0]      r_total;

    assign w_full      = (r_count == CW'(MAX_VERTICES));
    assign w_last      = r_count - CW'(1);
    assign o_last_addr = w_last[AW-1:0];

    always_comb begin
        n_count      = r_count;
        w_wr_en      = 1'b0;
        w_load       = 1'b0;
        w_res_inside = 1'b0;
        w_res_status = 1'b0;
        if (i_ctl.take) begin
            case (i_cmd)
                CMD_CLEAR: begin
                    n_count = '0;
                    w_load  = 1'b1;
                end
                CMD_APPEND: begin
                    w_load = 1'b1;
                    if (w_full) begin
                        w_res_status = 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                    end
                end
                CMD_QUERY: begin
                    w_load = (r_count == '0);
                end
                default: begin
                    w_load = 1'b1;
                end
            endcase
        end
        if (i_ctl.finish) begin
            w_load       = 1'b1;
            w_res_inside = r_parity;
        end
    end

    pip_ram #(
        .WIDTH(VTX_W),
        .DEPTH(MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data({i_coord_lat, i_coord_lon}),
        .i_rd_en  (i_ctl.rd_prime | i_ctl.rd_edge),
        .i_rd_addr(i_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_cur_lat = w_rd_data[VTX_W-1:LON_W];
    assign w_cur_lon = w_rd_data[LON_W-1:0];

    // split longitude differences for 17x32 multipliers
    assign w_pl_hi = r_dlon_p[32:16];
    assign w_pl_lo = {1'b0, r_dlon_p[15:0]};
    assign w_el_hi = r_dlon_e[32:16];
    assign w_el_lo = {1'b0, r_dlon_e[15:0]};

    // edge counts when the point is left of the crossing; flip for negative span
    assign w_cross = r_s3_neg ? (r_lhs > r_rhs) : (r_lhs < r_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_prime  <= 1'b0;
            r_rd_edge   <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rd_prime <= i_ctl.rd_prime;
            r_rd_edge  <= i_ctl.rd_edge;
            r_s1_vld   <= r_rd_edge;
            r_s2_vld   <= r_s1_vld;
            r_s3_vld   <= r_s2_vld;
            if (i_ctl.take) begin
                r_parity <= 1'b0;
            end else if (r_s3_vld && r_s3_str && w_cross) begin
                r_parity <= ~r_parity;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_plat <= i_coord_lat;
            r_plon <= i_coord_lon;
        end
        if (r_rd_prime || r_rd_edge) begin
            r_prev_lat <= w_cur_lat;
            r_prev_lon <= w_cur_lon;
        end
        // current vertex is i, previous is j
        r_s1_str <= (w_cur_lat > r_plat) ^ (r_prev_lat > r_plat);
        r_s1_neg <= (r_prev_lat < w_cur_lat);
        r_span   <= {r_prev_lat[LAT_W-1], r_prev_lat} - {w_cur_lat[LAT_W-1], w_cur_lat};
        r_dlat_p <= {r_plat[LAT_W-1], r_plat} - {w_cur_lat[LAT_W-1], w_cur_lat};
        r_dlon_p <= {r_plon[LON_W-1], r_plon} - {w_cur_lon[LON_W-1], w_cur_lon};
        r_dlon_e <= {r_prev_lon[LON_W-1], r_prev_lon} - {w_cur_lon[LON_W-1], w_cur_lon};

        r_s2_str <= r_s1_str;
        r_s2_neg <= r_s1_neg;
        r_lp_hi  <= w_pl_hi * r_span;
        r_lp_lo  <= w_pl_lo * r_span;
        r_rp_hi  <= w_el_hi * r_dlat_p;
        r_rp_lo  <= w_el_lo * r_dlat_p;

        r_s3_str <= r_s2_str;
        r_s3_neg <= r_s2_neg;
        r_lhs    <= {r_lp_hi[48], r_lp_hi, 16'b0} + {{17{r_lp_lo[48]}}, r_lp_lo};
        r_rhs    <= {r_rp_hi[48], r_rp_hi, 16'b0} + {{17{r_rp_lo[48]}}, r_rp_lo};

        if (w_load) begin
            r_inside <= w_res_inside;
            r_status <= w_res_status;
            r_total  <= TOTAL_W'(n_count);
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.out_hold = r_out_valid && i_out_stall;
    assign o_sts.busy     = r_rd_prime | r_rd_edge | r_s1_vld | r_s2_vld | r_s3_vld;

    assign o_out_valid    = r_out_valid;
    assign o_inside_res   = r_inside;
    assign o_status       = r_status;
    assign o_vertex_total = r_total;

    `PIP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_VERTICES),
        "vertex count above table depth")
    `PIP_ASSERT_NEXT(a_parity_quiet, !r_s3_vld && !i_ctl.take, $stable(r_parity),
        "parity changed without an edge result")
    `PIP_ASSERT_NEXT(a_out_held, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_inside) && $stable(r_status) && $stable(r_total),
        "stalled result changed")

endmodule

### rtl/core/pip_ctrl.sv
// Controller: accepts commands and sequences the edge walk over the vertex memory.
// Depends on pip_pkg and the assertion macro header.
`include "point_in_polygon_crossing_macros.svh"

module pip_ctrl #(
    parameter int MAX_VERTICES = 1024,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pip_pkg::CMD_W-1:0] i_cmd,
    input  pip_pkg::t_sts             i_sts,
    input  logic [AW-1:0]             i_last_addr,
    output logic                      o_in_stall,
    output pip_pkg::t_ctl             o_ctl,
    output logic [AW-1:0]             o_rd_addr
);

    import pip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_WALK  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;

    assign o_in_stall = (r_state != S_IDLE) || i_sts.out_hold;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        o_ctl     = '0;
        o_rd_addr = r_addr;
        case (r_state)
            S_IDLE: begin
                o_ctl.take = i_in_valid && !o_in_stall;
                if (o_ctl.take && i_cmd == CMD_QUERY && !i_sts.empty) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                // fetch the last vertex: it closes the ring with vertex 0
                o_ctl.rd_prime = 1'b1;
                o_rd_addr      = i_last_addr;
                n_addr         = '0;
                n_state        = S_WALK;
            end
            S_WALK: begin
                o_ctl.rd_edge = 1'b1;
                if (r_addr == i_last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    `PIP_ASSERT_NOW(a_walk_in_range, r_state == S_WALK, r_addr <= i_last_addr,
        "edge walk past last vertex")
    `PIP_ASSERT_NEXT(a_prime_to_walk, r_state == S_PRIME, r_state == S_WALK && r_addr == '0,
        "walk did not start at vertex 0")
    `PIP_ASSERT_NEXT(a_walk_to_drain, r_state == S_WALK && r_addr == i_last_addr,
        r_state == S_DRAIN, "walk did not end after last vertex")

endmodule

### rtl/core/point_in_polygon_crossing.sv
// Point-in-polygon unit, top level: controller plus datapath.
// Depends on pip_pkg, pip_ctrl, pip_datapath.

// Holds up to MAX_VERTICES polygon vertices (lat/lon, 1e-7 degree, signed) and
// answers point queries with the crossing-number test: the point is inside when
// an odd number of edges straddle its latitude with the crossing to its right.
// The edge test is an exact cross-multiply compare, no division. Clear, append
// and unused commands, and a query on an empty table, answer in the cycle after
// the transaction is taken. A query answers after one read of the vertex memory
// port per edge, plus the priming read of the last vertex and an edge pipeline
// (memory read, differences, split products, sums, compare). One command is in
// work at a time; input stall stays high while a query walks and while an unread
// result is stalled. An append to a full table is dropped and reports status 1.
module point_in_polygon_crossing #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pip_pkg::CMD_W-1:0]   i_cmd,
    input  logic [pip_pkg::LAT_W-1:0]   i_coord_lat,
    input  logic [pip_pkg::LON_W-1:0]   i_coord_lon,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_inside_res,
    output logic                        o_status,
    output logic [pip_pkg::TOTAL_W-1:0] o_vertex_total
);

    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    t_ctl          w_ctl;
    t_sts          w_sts;
    logic [AW-1:0] w_rd_addr, w_last_addr;

    pip_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (w_sts),
        .i_last_addr(w_last_addr),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl),
        .o_rd_addr  (w_rd_addr)
    );

    pip_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_rd_addr     (w_rd_addr),
        .i_cmd         (i_cmd),
        .i_coord_lat   (i_coord_lat),
        .i_coord_lon   (i_coord_lon),
        .i_out_stall   (i_out_stall),
        .o_sts         (w_sts),
        .o_last_addr   (w_last_addr),
        .o_out_valid   (o_out_valid),
        .o_inside_res  (o_inside_res),
        .o_status      (o_status),
        .o_vertex_total(o_vertex_total)
    );

endmodule

### tb/sv/pip_crossing_tb_pkg.sv
// Scoreboard for the point-in-polygon testbench: a vertex table mirror, the
// crossing-parity predictor and the queue of expected answers.
// Depends on pip_pkg.
package pip_crossing_tb_pkg;

    import pip_pkg::*;

    localparam int MAX_VTX    = 1024;
    localparam int REPORT_MAX = 10;

    // cmd encoding that leaves the table unchanged; the block still answers it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic               in_poly;
        logic               status;
        logic [TOTAL_W-1:0] total;
    } crossing_answer_t;

    class parity_board;
        logic signed [LAT_W-1:0] lat_tbl [MAX_VTX];
        logic signed [LON_W-1:0] lon_tbl [MAX_VTX];
        int unsigned             held;
        crossing_answer_t        answer_q [$];
        int unsigned             mismatches;
        int unsigned             checked;

        function new();
            held       = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Edge a-b counts when it straddles plat and plon lies left of the
        // crossing; cross-multiplied, flipped for a negative span.
        function bit edge_counts(longint plat, longint plon, int unsigned a,
                                 int unsigned b);
            longint lat_a, lat_b, lon_a, lon_b, span, lhs, rhs;
            lat_a = longint'(lat_tbl[a]);
            lat_b = longint'(lat_tbl[b]);
            lon_a = longint'(lon_tbl[a]);
            lon_b = longint'(lon_tbl[b]);
            if ((lat_a > plat) == (lat_b > plat)) return 1'b0;
            span = lat_b - lat_a;
            lhs  = (plon - lon_a) * span;
            rhs  = (lon_b - lon_a) * (plat - lat_a);
            return (span > 0) ? (lhs < rhs) : (lhs > rhs);
        endfunction

        function bit crossing_parity(longint plat, longint plon);
            bit          parity;
            int unsigned j;
            parity = 1'b0;
            if (held == 0) return 1'b0;
            j = held - 1;
            for (int unsigned i = 0; i < held; i++) begin
                parity ^= edge_counts(plat, plon, i, j);
                j = i;
            end
            return parity;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] lat,
                                   logic [LON_W-1:0] lon);
            crossing_answer_t want;
            want = '0;
            case (cmd)
                CMD_CLEAR: held = 0;
                CMD_APPEND: begin
                    if (held < MAX_VTX) begin
                        lat_tbl[held] = $signed(lat);
                        lon_tbl[held] = $signed(lon);
                        held++;
                    end else begin
                        want.status = 1'b1;
                    end
                end
                CMD_QUERY: want.in_poly = crossing_parity(longint'($signed(lat)),
                                                          longint'($signed(lon)));
                default: ;
            endcase
            want.total = TOTAL_W'(held);
            answer_q = {answer_q, want};
        endfunction

        function void check_answer(logic in_poly, logic status, logic [TOTAL_W-1:0] total);
            crossing_answer_t want;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: inside=%0d status=%0d total=%0d",
                             in_poly, status, total);
                return;
            end
            want = answer_q.pop_front();
            if (want.in_poly !== in_poly || want.status !== status || want.total !== total)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"result %0d mismatch: expected inside=%0d status=%0d total=%0d,",
                              " got inside=%0d status=%0d total=%0d"}, checked,
                             want.in_poly, want.status, want.total, in_poly, status, total);
            end
            checked++;
        endfunction

        function int unsigned pending();
            return answer_q.size();
        endfunction
    endclass

endpackage

### tb/sv/point_in_polygon_crossing_tb.sv
// Top-level testbench for point_in_polygon_crossing: directed corner cases,
// random polygons with probes, and a full-table phase, all under random idling.
// Depends on pip_pkg, pip_crossing_tb_pkg and the block's RTL.
module point_in_polygon_crossing_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;
    import pip_crossing_tb_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int END_WAIT    = 20;
    localparam int RANDOM_ITEMS = 580;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [CMD_W-1:0]   i_cmd        = CMD_CLEAR;
    logic [LAT_W-1:0]   i_coord_lat  = '0;
    logic [LON_W-1:0]   i_coord_lon  = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_inside_res;
    logic               o_status;
    logic [TOTAL_W-1:0] o_vertex_total;

    parity_board board = new();

    int  cycle_count = 0;
    int  stall_hold  = 0;
    int  items_sent  = 0;
    bit  quiet_in    = 1'b0;
    bit  quiet_out   = 1'b0;

    point_in_polygon_crossing #(.MAX_VERTICES(MAX_VTX)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_coord_lat    (i_coord_lat),
        .i_coord_lon    (i_coord_lon),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .o_status       (o_status),
        .o_vertex_total (o_vertex_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint rnd_span(longint rad);
        return longint'($urandom_range(0, 32'(2 * rad))) - rad;
    endfunction

    function automatic longint rand_lat();
        return longint'($urandom_range(0, 1800000000)) - 64'sd900000000;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
    endfunction

    // result side: check accepted transactions, then pick the next stall level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_answer(o_inside_res, o_status, o_vertex_total);
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (quiet_out) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold  <= pick_gap();
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input longint lat, input longint lon);
        int gap;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_coord_lat <= lat[LAT_W-1:0];
        i_coord_lon <= lon[LON_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        board.note_command(cmd, lat[LAT_W-1:0], lon[LON_W-1:0]);
        if (cmd != CMD_UNUSED) items_sent++;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every expected answer is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    initial begin
        int     target;
        longint side_len, step, lat, lon;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused command, clear on empty
        send(CMD_QUERY, 0, 0);
        send(CMD_UNUSED, -64'sd1, -64'sd1);
        send(CMD_CLEAR, 64'sd1073741823, 64'sd2147483647);

        // triangle spanning the full stated range, probes on vertices and edges
        send(CMD_APPEND, -64'sd900000000, -64'sd1800000000);
        send(CMD_APPEND, 64'sd900000000, -64'sd1800000000);
        send(CMD_APPEND, 0, 64'sd1800000000);
        send(CMD_QUERY, 0, 0);
        send(CMD_QUERY, 0, 64'sd1800000000);
        send(CMD_QUERY, 64'sd900000000, 0);
        send(CMD_QUERY, 0, -64'sd1800000000);
        send(CMD_QUERY, -64'sd900000000, -64'sd1800000000);
        send(CMD_UNUSED, -64'sd1073741824, -64'sd2147483648);

        // triangle on the raw two's-complement extremes
        send(CMD_CLEAR, 0, 0);
        send(CMD_APPEND, -64'sd1073741824, -64'sd2147483648);
        send(CMD_APPEND, 64'sd1073741823, -64'sd2147483648);
        send(CMD_APPEND, 0, 64'sd2147483647);
        send(CMD_QUERY, 0, 0);
        send(CMD_QUERY, -64'sd1073741824, 64'sd2147483647);

        // one and two vertices, then a square with horizontal edges
        send(CMD_CLEAR, 0, 0);
        send(CMD_APPEND, 0, 0);
        send(CMD_QUERY, 0, -64'sd5);
        send(CMD_APPEND, 0, 100);
        send(CMD_QUERY, 0, 50);
        send(CMD_APPEND, 100, 100);
        send(CMD_APPEND, 100, 0);
        send(CMD_QUERY, 50, 50);
        send(CMD_QUERY, 0, 50);
        drain();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin : one_polygon
            longint vlat [64];
            longint vlon [64];
            int     nv, nq, mode, r, pick, k;
            longint clat, clon, rad, qlat, qlon;
            mode = $urandom_range(0, 9);
            r    = $urandom_range(0, 19);
            nv   = (r == 0) ? $urandom_range(1, 2) :
                   (r == 1) ? $urandom_range(30, 64) : $urandom_range(3, 12);
            // small radius makes shared latitudes and collinear points likely
            rad  = (mode < 4) ? longint'($urandom_range(1, 2000)) :
                                longint'($urandom_range(1000, 400000000));
            clat = rand_lat();
            clon = rand_lon();
            if ($urandom_range(0, 5) == 0) begin
                quiet_in  = ($urandom_range(0, 2) == 0);
                quiet_out = ($urandom_range(0, 2) == 0);
            end
            // now and then grow the current table instead of starting over
            if ($urandom_range(0, 9) != 0 || board.held + nv > MAX_VTX - 64)
                send(CMD_CLEAR, longint'($urandom()), longint'($urandom()));
            for (k = 0; k < nv; k++) begin
                if (mode >= 8) begin
                    vlat[k] = longint'($urandom());
                    vlon[k] = longint'($urandom());
                end else begin
                    vlat[k] = clat + rnd_span(rad);
                    vlon[k] = clon + rnd_span(rad);
                end
                send(CMD_APPEND, vlat[k], vlon[k]);
            end
            nq = $urandom_range(2, 8);
            for (k = 0; k < nq; k++) begin
                pick = $urandom_range(0, 7);
                r    = $urandom_range(0, nv - 1);
                if (mode >= 8) begin
                    qlat = longint'($urandom());
                    qlon = longint'($urandom());
                end else begin
                    qlat = clat + rnd_span(rad + rad / 4 + 1);
                    qlon = clon + rnd_span(rad + rad / 4 + 1);
                end
                case (pick)
                    0: begin
                        qlat = vlat[r];
                        qlon = vlon[r];
                    end
                    1: qlat = vlat[r];
                    2: qlon = vlon[r];
                    default: ;
                endcase
                if ($urandom_range(0, 11) == 0)
                    send(CMD_UNUSED, longint'($urandom()), longint'($urandom()));
                send(CMD_QUERY, qlat, qlon);
            end
            if ($urandom_range(0, 7) == 0) drain();
        end
        drain();

        // fill the table with a square's perimeter, then overflow it
        quiet_in  = 1'b1;
        quiet_out = 1'b0;
        side_len  = 64'sd768000000;
        step      = 64'sd6000000;
        send(CMD_CLEAR, 0, 0);
        for (int k = 0; k < MAX_VTX; k++) begin
            case (k / 256)
                0: begin
                    lat = -side_len;
                    lon = -side_len + (k % 256) * step;
                end
                1: begin
                    lat = -side_len + (k % 256) * step;
                    lon = side_len;
                end
                2: begin
                    lat = side_len;
                    lon = side_len - (k % 256) * step;
                end
                default: begin
                    lat = side_len - (k % 256) * step;
                    lon = -side_len;
                end
            endcase
            send(CMD_APPEND, lat, lon);
        end
        quiet_in = 1'b0;
        send(CMD_APPEND, 1, 1);
        send(CMD_APPEND, rand_lat(), rand_lon());
        send(CMD_UNUSED, 0, 0);
        send(CMD_QUERY, 0, 0);
        send(CMD_QUERY, 0, side_len + 1000);
        send(CMD_QUERY, side_len, 0);
        send(CMD_QUERY, -side_len, -side_len);
        send(CMD_QUERY, 500000, -side_len);
        for (int k = 0; k < 3; k++)
            send(CMD_QUERY, rnd_span(side_len + side_len / 8), rnd_span(side_len + side_len / 8));
        send(CMD_CLEAR, 0, 0);
        send(CMD_QUERY, 0, 0);

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
